// ===== rtl/esd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape sequence decoder package
// Shared types, character codes and helper functions.
// ----------------------------------------------------------------------------
package esd_pkg;

   localparam int QDEPTH = 4;
   localparam int QAW    = $clog2(QDEPTH);
   localparam int QCW    = $clog2(QDEPTH + 1);
   localparam int MAXOUT = 3;

   localparam logic [7:0] CHR_BSL = 8'h5C;
   localparam logic [7:0] CHR_X   = 8'h78;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_line;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_end;
      logic       line_done;
   } rsp_type;

   // decoded bytes of one request; cnt is 1..3
   typedef struct packed {
      logic [MAXOUT-1:0][7:0] bytes;
      logic [1:0]             cnt;
      logic                   eol;
   } esd_entry_type;

   typedef struct packed {
      logic          valid;
      esd_entry_type entry;
   } esd_push_type;

   typedef struct packed {
      logic          valid;
      esd_entry_type entry;
   } esd_head_type;

   typedef enum logic [3:0] {
      PH_PLAIN = 4'b0001,
      PH_ESC   = 4'b0010,
      PH_HEX0  = 4'b0100,
      PH_HEX1  = 4'b1000
   } esd_phase_type;

   // {is_hex, value}
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, 4'(b - 8'h30)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r = {1'b1, 4'(b - 8'h57)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r = {1'b1, 4'(b - 8'h37)};
      end
      return r;
   endfunction

   // simple escapes; anything else (including backslash) maps to itself
   function automatic logic [7:0] esc_map(input logic [7:0] b);
      logic [7:0] r;
      case (b)
         8'h6E: r = 8'h0A;  // n
         8'h72: r = 8'h0D;  // r
         8'h74: r = 8'h09;  // t
         8'h76: r = 8'h0B;  // v
         8'h62: r = 8'h08;  // b
         8'h61: r = 8'h07;  // a
         8'h66: r = 8'h0C;  // f
         default: r = b;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/escape_sequence_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape sequence decoder
// Decodes C-style backslash escapes in a byte stream, 0 to 3 bytes out each.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  req_      in         req_valid / req_stall  req_type (in_byte, end_of_line)
//  rsp_      out        rsp_valid / rsp_stall  rsp_type (out_byte, run_end,
//                                                        line_done)
//
//  One request per cycle enters while the 4-entry group queue has room.
//  The back end sends one byte per cycle while rsp_stall is low, so a request
//  that expands to two or three bytes holds the response side until all are sent.
//  A request's first response passes through the queue entry and then the registered response output.
//  Reset clears phase, queue pointers and the response valid.
//  rsp_stall backs up into the queue and then into req_stall.
// ----------------------------------------------------------------------------
module escape_sequence_decoder import esd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   esd_push_type push;
   esd_head_type head;
   logic         q_full;
   logic         pop;

   esd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .push      (push)
   );

   esd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (q_full),
      .head  (head)
   );

   esd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/esd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape sequence decoder front end
// Accepts raw bytes, tracks escape phase, builds the decoded byte group.
// ----------------------------------------------------------------------------
module esd_front import esd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_type      req_data,
   input  logic         q_full,
   output esd_push_type push
);

   esd_phase_type phase_ff, phase_in;
   logic [7:0]    held_ff, held_in;
   esd_entry_type ent;
   logic [4:0]    hx;
   logic [4:0]    hx_held;
   logic          do_plain;
   logic [1:0]    pos;
   logic          accept;
   logic [7:0]    b;
   logic          eol;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign b         = req_data.in_byte;
   assign eol       = req_data.end_of_line;

   always_comb begin
      hx        = hex_digit(b);
      hx_held   = hex_digit(held_ff);
      phase_in  = phase_ff;
      held_in   = held_ff;
      ent.bytes = '0;
      ent.cnt   = 2'd0;
      ent.eol   = eol;
      do_plain  = 1'b0;
      pos       = 2'd0;
      case (phase_ff)
         PH_PLAIN: begin
            do_plain = 1'b1;
         end
         PH_ESC: begin
            if (b == CHR_X) begin
               if (eol) begin
                  ent.bytes[0] = CHR_X;
                  ent.cnt      = 2'd1;
                  phase_in     = PH_PLAIN;
               end else begin
                  phase_in = PH_HEX0;
               end
            end else begin
               ent.bytes[0] = esc_map(b);
               ent.cnt      = 2'd1;
               phase_in     = PH_PLAIN;
            end
         end
         PH_HEX0: begin
            if (hx[4] && !eol) begin
               held_in  = b;
               phase_in = PH_HEX1;
            end else begin
               ent.bytes[0] = CHR_X;
               ent.cnt      = 2'd1;
               do_plain     = 1'b1;
               pos          = 2'd1;
            end
         end
         PH_HEX1: begin
            if (hx[4]) begin
               ent.bytes[0] = {hx_held[3:0], hx[3:0]};
               ent.cnt      = 2'd1;
               phase_in     = PH_PLAIN;
            end else begin
               // failed second digit: replay 'x' and the held digit, then decode the byte as plain
               ent.bytes[0] = CHR_X;
               ent.bytes[1] = held_ff;
               ent.cnt      = 2'd2;
               do_plain     = 1'b1;
               pos          = 2'd2;
            end
         end
         default: begin
            phase_in = PH_PLAIN;
         end
      endcase
      if (do_plain) begin
         if (b == CHR_BSL && !eol) begin
            phase_in = PH_ESC;
         end else begin
            ent.bytes[pos] = b;
            ent.cnt        = pos + 2'd1;
            phase_in       = PH_PLAIN;
         end
      end
      if (eol) begin
         phase_in = PH_PLAIN;
      end
   end

   assign push.valid = accept && (ent.cnt != 2'd0);
   assign push.entry = ent;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_PLAIN;
         held_ff  <= 8'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

endmodule

// ===== rtl/esd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape sequence decoder queue
// Short FIFO of decoded byte groups between front and back.
// ----------------------------------------------------------------------------
module esd_queue import esd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  esd_push_type push,
   input  logic         pop,
   output logic         full,
   output esd_head_type head
);

   esd_entry_type q_ff [QDEPTH];
   logic [QAW-1:0] wr_ff, wr_in;
   logic [QAW-1:0] rd_ff, rd_in;
   logic [QCW-1:0] cnt_ff, cnt_in;
   logic           do_push;
   logic           do_pop;

   assign full       = (cnt_ff == QCW'(QDEPTH));
   assign head.valid = (cnt_ff != '0);
   assign head.entry = q_ff[rd_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop  ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + QCW'(do_push) - QCW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ff] <= push.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== rtl/esd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape sequence decoder back end
// Serializes each byte group onto the response channel, one byte a cycle while not stalled.
// ----------------------------------------------------------------------------
module esd_back import esd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  esd_head_type head,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_data
);

   logic [1:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;
   logic       advance;
   logic       last;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign last    = (idx_ff == head.entry.cnt - 2'd1);
   assign pop     = advance && head.valid && last;

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in = head.valid;
         if (head.valid) begin
            rsp_in.out_byte  = head.entry.bytes[idx_ff];
            rsp_in.run_end   = last;
            rsp_in.line_done = last && head.entry.eol;
            idx_in           = last ? 2'd0 : idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/esd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape sequence decoder checker
// Port-level checks, bound to the top level.
// ----------------------------------------------------------------------------
module esd_checker import esd_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   a_line_done_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.line_done && !rsp_data.run_end))
      else $error("line_done without run_end");

   a_rsp_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_req_open_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_stall)
      else $error("request stalled right after reset");

endmodule

bind escape_sequence_decoder esd_checker u_esd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== tb/escape_sequence_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape sequence decoder testbench
// Streams text bytes with directed and random escape sequences into the
// decoder and checks every decoded byte and its run_end and line_done flags
// against a cycle-free model of the decoder. Random gaps and stalls on both
// channels, one long response hold-off to back the block up into req_stall.
// ----------------------------------------------------------------------------
module escape_sequence_decoder_tb;
   import esd_pkg::*;

   localparam int CLK_PERIOD   = 20;
   localparam int RANDOM_ITEMS = 143;
   localparam int IDLE_LIMIT   = 1000;
   localparam int TAIL_CYCLES  = 8;
   localparam int MAX_REPORTS  = 10;
   localparam int HOLD_AT_REQ  = 40;
   localparam int HOLD_CYCLES  = 80;

   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_VT  = 8'h0B;
   localparam logic [7:0] CH_BS  = 8'h08;
   localparam logic [7:0] CH_BEL = 8'h07;
   localparam logic [7:0] CH_FF  = 8'h0C;

   localparam logic [7:0] KEY_N = "n";
   localparam logic [7:0] KEY_R = "r";
   localparam logic [7:0] KEY_T = "t";
   localparam logic [7:0] KEY_V = "v";
   localparam logic [7:0] KEY_B = "b";
   localparam logic [7:0] KEY_A = "a";
   localparam logic [7:0] KEY_F = "f";

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   escape_sequence_decoder u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   req_type pending_reqs[$];
   rsp_type expected_bytes[$];
   logic [7:0] decoded_now[$];

   // decoder model state
   esd_phase_type phase_now = PH_PLAIN;
   logic [7:0]    held_char = '0;

   logic req_taken = 1'b0;
   int   accepted_reqs = 0;
   int   received_bytes = 0;
   int   lines_seen = 0;
   int   hex_decoded = 0;
   int   failures = 0;
   int   gap_left = 0;
   int   stall_left = 0;
   int   hold_left = 0;
   bit   hold_done = 1'b0;
   int   idle_cycles = 0;

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   function automatic bit calm_window();
      return accepted_reqs >= 100 && accepted_reqs < 140;
   endfunction

   // -1 when not a hex character
   function automatic int hex_of(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return -1;
   endfunction

   function automatic logic [7:0] escape_value(input logic [7:0] c);
      case (c)
         KEY_N: return CH_LF;
         KEY_R: return CH_CR;
         KEY_T: return CH_TAB;
         KEY_V: return CH_VT;
         KEY_B: return CH_BS;
         KEY_A: return CH_BEL;
         KEY_F: return CH_FF;
         default: return c;
      endcase
   endfunction

   task automatic take_plain(input logic [7:0] c, input bit eol);
      if (c == CHR_BSL && !eol) begin
         phase_now = PH_ESC;
      end else begin
         decoded_now.push_back(c);
         phase_now = PH_PLAIN;
      end
   endtask

   task automatic decode_request(input req_type r);
      logic [7:0] c;
      bit         eol;
      int         v;
      rsp_type    e;
      c = r.in_byte;
      eol = r.end_of_line;
      decoded_now.delete();
      case (phase_now)
         PH_PLAIN: begin
            take_plain(c, eol);
         end
         PH_ESC: begin
            if (c == CHR_X) begin
               if (eol) begin
                  decoded_now.push_back(CHR_X);
                  phase_now = PH_PLAIN;
               end else begin
                  phase_now = PH_HEX0;
               end
            end else begin
               decoded_now.push_back(escape_value(c));
               phase_now = PH_PLAIN;
            end
         end
         PH_HEX0: begin
            if (hex_of(c) >= 0 && !eol) begin
               held_char = c;
               phase_now = PH_HEX1;
            end else begin
               decoded_now.push_back(CHR_X);
               phase_now = PH_PLAIN;
               take_plain(c, eol);
            end
         end
         default: begin
            v = hex_of(c);
            if (v >= 0) begin
               decoded_now.push_back({4'(hex_of(held_char)), 4'(v)});
               phase_now = PH_PLAIN;
               hex_decoded++;
            end else begin
               // failed second digit: 'x', the held digit, then the byte as text
               decoded_now.push_back(CHR_X);
               decoded_now.push_back(held_char);
               phase_now = PH_PLAIN;
               take_plain(c, eol);
            end
         end
      endcase
      if (eol) phase_now = PH_PLAIN;
      foreach (decoded_now[k]) begin
         e.out_byte  = decoded_now[k];
         e.run_end   = (k == decoded_now.size() - 1);
         e.line_done = e.run_end && eol;
         expected_bytes.push_back(e);
      end
   endtask

   task automatic report_failure(input string msg);
      failures++;
      if (failures <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   // request and response monitor, with the model run on every accepted request
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         phase_now <= PH_PLAIN;
         held_char <= '0;
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            decode_request(req_data);
            accepted_reqs <= accepted_reqs + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            received_bytes++;
            if (rsp_data.line_done) lines_seen++;
            if (expected_bytes.size() == 0) begin
               report_failure($sformatf("unexpected byte %h run_end=%b line_done=%b",
                  rsp_data.out_byte, rsp_data.run_end, rsp_data.line_done));
            end else begin
               e = expected_bytes.pop_front();
               if (rsp_data.out_byte !== e.out_byte || rsp_data.run_end !== e.run_end ||
                   rsp_data.line_done !== e.line_done) begin
                  report_failure($sformatf(
                     "byte %h/%h run_end %b/%b line_done %b/%b (expected/actual)",
                     e.out_byte, rsp_data.out_byte, e.run_end, rsp_data.run_end,
                     e.line_done, rsp_data.line_done));
               end
            end
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      int r;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (pending_reqs.size() != 0) begin
            req_valid <= 1'b1;
            req_data <= pending_reqs.pop_front();
            r = $urandom_range(0, 99);
            if (calm_window() || r < 55) gap_left <= 0;
            else if (r < 90) gap_left <= $urandom_range(1, 3);
            else gap_left <= $urandom_range(10, 30);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response stall: random stalls plus one long hold-off
   always @(negedge clock) begin
      int r;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && accepted_reqs >= HOLD_AT_REQ) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES - 1;
         hold_done <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if (calm_window()) begin
         rsp_stall <= 1'b0;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 25) begin
            rsp_stall <= 1'b1;
            stall_left <= $urandom_range(0, 2);
         end else if (r < 32) begin
            rsp_stall <= 1'b1;
            stall_left <= $urandom_range(8, 20);
         end else begin
            rsp_stall <= 1'b0;
            stall_left <= $urandom_range(0, 7);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("ERROR: no request or response moved for %0d cycles", IDLE_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic add_item(input logic [7:0] c, input bit eol);
      req_type r;
      r.in_byte = c;
      r.end_of_line = eol;
      pending_reqs.push_back(r);
   endtask

   function automatic logic [7:0] random_hex_char();
      int v;
      v = $urandom_range(0, 21);
      if (v < 10) return 8'("0") + 8'(v);
      if (v < 16) return 8'("a") + 8'(v - 10);
      return 8'("A") + 8'(v - 16);
   endfunction

   function automatic logic [7:0] random_escape_key();
      case ($urandom_range(0, 9))
         0: return KEY_N;
         1: return KEY_R;
         2: return KEY_T;
         3: return KEY_V;
         4: return KEY_B;
         5: return KEY_A;
         6: return KEY_F;
         7: return CHR_BSL;
         8: return "q";
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // mid-sequence line ends are rare so most escapes complete
   function automatic bit stray_eol();
      return $urandom_range(0, 19) == 0;
   endfunction

   initial begin
      int  directed;
      int  pick;
      bit  eol;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_item("A", 1'b0);
      add_item(8'h00, 1'b0);
      add_item(CHR_BSL, 1'b0); add_item(KEY_N, 1'b0);
      add_item(CHR_BSL, 1'b0); add_item(CHR_BSL, 1'b0);
      add_item(CHR_BSL, 1'b0); add_item("q", 1'b0);
      add_item(CHR_BSL, 1'b0); add_item(CHR_X, 1'b0);
      add_item("a", 1'b0);     add_item("F", 1'b0);
      // bad first hex digit
      add_item(CHR_BSL, 1'b0); add_item(CHR_X, 1'b0); add_item("g", 1'b0);
      // bad second hex digit that opens a new escape
      add_item(CHR_BSL, 1'b0); add_item(CHR_X, 1'b0); add_item("3", 1'b0);
      add_item(CHR_BSL, 1'b0); add_item(KEY_T, 1'b0);
      add_item(8'hFF, 1'b1);
      // escapes cut by the end of the line
      add_item(CHR_BSL, 1'b1);
      add_item(CHR_BSL, 1'b0); add_item(CHR_X, 1'b1);
      add_item(CHR_BSL, 1'b0); add_item(CHR_X, 1'b0); add_item("7", 1'b1);
      directed = pending_reqs.size();

      while (pending_reqs.size() - directed < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         eol = ($urandom_range(0, 5) == 0);
         if (pick < 35) begin
            add_item(8'($urandom_range(0, 255)), eol);
         end else if (pick < 60) begin
            add_item(CHR_BSL, stray_eol());
            add_item(random_escape_key(), eol);
         end else if (pick < 85) begin
            add_item(CHR_BSL, 1'b0);
            add_item(CHR_X, stray_eol());
            add_item(random_hex_char(), stray_eol());
            add_item(random_hex_char(), eol);
         end else begin
            add_item(CHR_BSL, 1'b0);
            add_item(CHR_X, 1'b0);
            if ($urandom_range(0, 1) == 1) add_item(random_hex_char(), stray_eol());
            add_item(8'($urandom_range(0, 255)), eol);
         end
      end

      while (pending_reqs.size() != 0 || req_valid) @(posedge clock);
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d requests (%0d directed), received %0d decoded bytes on %0d lines.",
         accepted_reqs, directed, received_bytes, lines_seen);
      $display("Covered %0d complete hex escapes, one %0d-cycle response hold-off, %0d failures.",
         hex_decoded, HOLD_CYCLES, failures);
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
